// ----- hw/rtl/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types, register codes and helpers for the box filter downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

	localparam int SUM_W     = 12;
	localparam int BYTE_W    = 8;
	localparam int OUT_CMP_W = 3;
	localparam int OUT_COL_W = 12;
	localparam int OUT_ROW_W = 12;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 5;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// register index, byte address is 4x this
	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COMPONENTS   = 3'd2,
		REG_X_FACTOR     = 3'd3,
		REG_Y_FACTOR     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] sample;
		logic       frame_start;
	} px_in_t;

	typedef struct packed {
		logic [7:0]  out_value;
		logic [2:0]  out_component;
		logic [11:0] out_col;
		logic [11:0] out_row;
		logic        frame_end;
	} px_out_t;

	// per-beat flags from the position sequencer
	typedef struct packed {
		logic run_end;
		logic band_end;
		logic row0;
		logic frame_end;
	} ctl_t;

	// output coordinates carried down the pipe
	typedef struct packed {
		logic [OUT_CMP_W-1:0] comp;
		logic [OUT_COL_W-1:0] col;
		logic [OUT_ROW_W-1:0] row;
		logic                 last;
	} tag_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bfd_seq.sv -----
// ----------------------------------------------------------------------------
// bfd_seq
// Raster position counters and per-component horizontal run sums.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_seq #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_HEIGHT     = 4096,
	parameter int MAX_COMPONENTS = 8,
	parameter int MAX_FACTOR     = 16,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	localparam int KW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
	localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   acc,
	input  wire bfd_pkg::px_in_t        din,
	input  wire logic [CW:0]            w_eff,
	input  wire logic [HW:0]            h_eff,
	input  wire logic [KW:0]            nc_eff,
	input  wire logic [FW:0]            xf_eff,
	input  wire logic [FW:0]            yf_eff,
	output logic [bfd_pkg::SUM_W-1:0]   rs_new,
	output logic [FW-1:0]               grp,
	output logic [FW-1:0]               rib,
	output logic [KW-1:0]               comp,
	output logic [CW-1:0]               ocol,
	output logic [HW-1:0]               orow,
	output bfd_pkg::ctl_t               ctl
);
	import bfd_pkg::*;

	logic [KW-1:0]    comp_q, comp_n;
	logic [CW-1:0]    pcol_q, pcol_n, pcol_c, ocol_q, ocol_n;
	logic [FW-1:0]    grp_q, grp_n, rib_q, rib_n;
	logic [HW-1:0]    prow_q, prow_n, prow_c, orow_q, orow_n;
	logic [SUM_W-1:0] rs_q [MAX_COMPONENTS];
	logic             last_comp, row_end, run_end, img_end, band_end;
	logic [SUM_W-1:0] samp_ext;

	// frame start clears every position before the beat is used
	always_comb begin
		comp   = din.frame_start ? '0 : comp_q;
		pcol_c = din.frame_start ? '0 : pcol_q;
		grp    = din.frame_start ? '0 : grp_q;
		ocol   = din.frame_start ? '0 : ocol_q;
		rib    = din.frame_start ? '0 : rib_q;
		prow_c = din.frame_start ? '0 : prow_q;
		orow   = din.frame_start ? '0 : orow_q;

		last_comp = ({1'b0, comp} + 1'b1) >= nc_eff;
		row_end   = ({1'b0, pcol_c} + 1'b1) >= w_eff;
		run_end   = row_end || (({1'b0, grp} + 1'b1) >= xf_eff);
		img_end   = ({1'b0, prow_c} + 1'b1) >= h_eff;
		band_end  = img_end || (({1'b0, rib} + 1'b1) >= yf_eff);

		ctl.run_end   = run_end;
		ctl.band_end  = band_end;
		ctl.row0      = (rib == '0);
		ctl.frame_end = img_end && row_end && last_comp;

		samp_ext = {{(SUM_W-8){1'b0}}, din.sample};
		rs_new   = (grp == '0) ? samp_ext : sat_add(rs_q[comp], samp_ext);
	end

	always_comb begin
		comp_n = comp;
		pcol_n = pcol_c;
		grp_n  = grp;
		ocol_n = ocol;
		rib_n  = rib;
		prow_n = prow_c;
		orow_n = orow;
		if (!last_comp) begin
			comp_n = comp + 1'b1;
		end else begin
			comp_n = '0;
			if (!run_end) begin
				grp_n  = grp + 1'b1;
				pcol_n = pcol_c + 1'b1;
			end else begin
				grp_n = '0;
				if (!row_end) begin
					pcol_n = pcol_c + 1'b1;
					ocol_n = ocol + 1'b1;
				end else begin
					pcol_n = '0;
					ocol_n = '0;
					if (img_end) begin
						prow_n = '0;
						rib_n  = '0;
						orow_n = '0;
					end else begin
						prow_n = prow_c + 1'b1;
						if (band_end) begin
							rib_n  = '0;
							orow_n = orow + 1'b1;
						end else begin
							rib_n = rib + 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= '0;
			pcol_q <= '0;
			grp_q  <= '0;
			ocol_q <= '0;
			rib_q  <= '0;
			prow_q <= '0;
			orow_q <= '0;
			for (int i = 0; i < MAX_COMPONENTS; i++) begin
				rs_q[i] <= '0;
			end
		end else if (acc) begin
			comp_q     <= comp_n;
			pcol_q     <= pcol_n;
			grp_q      <= grp_n;
			ocol_q     <= ocol_n;
			rib_q      <= rib_n;
			prow_q     <= prow_n;
			orow_q     <= orow_n;
			rs_q[comp] <= rs_new;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bfd_div.sv -----
// ----------------------------------------------------------------------------
// bfd_div
// Divide a saturated sum by a small count through a reciprocal table,
// registered product, result clamped to one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_div #(
	parameter int MAX_FACTOR = 16,
	localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [bfd_pkg::SUM_W-1:0]  dividend,
	input  wire logic [FW-1:0]              dsel,
	output logic [7:0]                      quo
);
	import bfd_pkg::*;

	// exact floor for every 12-bit dividend with KS this large
	localparam int KS = SUM_W + FW + 1;
	localparam int MW = KS + 1;
	localparam int PW = SUM_W + MW;

	logic [MW-1:0] rcp_tab [MAX_FACTOR];
	logic [PW-1:0] prod_q;
	logic [SUM_W:0] q;

	for (genvar d = 1; d <= MAX_FACTOR; d++) begin : g_rcp
		localparam longint unsigned RCP = ((longint'(1) << KS) + d - 1) / d;
		assign rcp_tab[d-1] = MW'(RCP);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {{MW{1'b0}}, dividend} * {{SUM_W{1'b0}}, rcp_tab[dsel]};
		end
	end

	always_comb begin
		q   = prod_q[PW-1:KS];
		quo = (|q[SUM_W:8]) ? 8'hFF : q[7:0];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bfd_colmem.sv -----
// ----------------------------------------------------------------------------
// bfd_colmem
// Column band sum store: one read port, one write port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_colmem #(
	parameter int AW = 15
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [AW-1:0]              rd_addr,
	output logic [bfd_pkg::SUM_W-1:0]       rd_data_q,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              wr_addr,
	input  wire logic [bfd_pkg::SUM_W-1:0]  wr_data
);
	import bfd_pkg::*;

	logic [SUM_W-1:0] mem_q [2**AW];

	// read-before-write on a shared address
	always_ff @(posedge clk) begin
		if (en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/box_filter_image_downscale.sv -----
// The sample beat that completes a result passes stages s1 to s4, then the output register.
// Throughput: one sample per cycle; all stages advance together and hold while
// a result beat waits in the output register.
// Column sums are read, modified and written back over three stages, with
// forwarding from the two writes still in flight.
// Reset clears counters, run sums and valid bits; registers go to 1; column sums are not cleared.
// ----------------------------------------------------------------------------
// box_filter_image_downscale
// Integer-factor box filter downscaler: horizontal run average per row,
// vertical band average per output column and component.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_image_downscale #(
	parameter int MAX_WIDTH      = 4096,
	parameter int MAX_HEIGHT     = 4096,
	parameter int MAX_COMPONENTS = 8,
	parameter int MAX_FACTOR     = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_ready,
	input  wire bfd_pkg::px_in_t               sample_data,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output bfd_pkg::px_out_t                   result_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bfd_pkg::APB_AW-1:0]    paddr,
	input  wire logic [bfd_pkg::APB_DW-1:0]    pwdata,
	output logic [bfd_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);
	import bfd_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int KW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
	localparam int AW = CW + KW;

	typedef logic [CW:0] wlim_t;
	typedef logic [HW:0] hlim_t;
	typedef logic [KW:0] klim_t;
	typedef logic [FW:0] flim_t;

	// configuration
	logic [12:0] cfg_w_q, cfg_h_q;
	logic [3:0]  cfg_nc_q;
	logic [4:0]  cfg_xf_q, cfg_yf_q;
	logic        cfg_wr;
	reg_idx_t    reg_sel;
	wlim_t       w_eff;
	hlim_t       h_eff;
	klim_t       nc_eff;
	flim_t       xf_eff, yf_eff;

	// pipeline
	logic             en, acc;
	logic [SUM_W-1:0] rs_new;
	logic [FW-1:0]    grp0, rib0;
	logic [KW-1:0]    comp0;
	logic [CW-1:0]    ocol0;
	logic [HW-1:0]    orow0;
	ctl_t             ctl0;
	tag_t             tag0;

	logic             v_s1, v_s2, v_s3, v_s4;
	ctl_t             ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	tag_t             tag_s1, tag_s2, tag_s3, tag_s4;
	logic [AW-1:0]    idx_s1, idx_s2, idx_s3, idx_s4;
	logic [SUM_W-1:0] rs_s1;
	logic [FW-1:0]    grp_s1;
	logic [FW-1:0]    rib_s1, rib_s2, rib_s3;
	logic [SUM_W-1:0] rd_s1, rd_s2;
	logic [SUM_W-1:0] col_s3, col_s4;
	logic [7:0]       avg_s2, quo_s4;
	logic [SUM_W-1:0] col_base, col_new;
	logic             col_we, wv_s3, wv_s4, res_s4;

	logic             result_valid_q;
	px_out_t          result_q;

	// ------------------------------------------------------------------
	// APB registers
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q  <= 13'd1;
			cfg_h_q  <= 13'd1;
			cfg_nc_q <= 4'd1;
			cfg_xf_q <= 5'd1;
			cfg_yf_q <= 5'd1;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_IMAGE_WIDTH:  cfg_w_q  <= pwdata[12:0];
				REG_IMAGE_HEIGHT: cfg_h_q  <= pwdata[12:0];
				REG_COMPONENTS:   cfg_nc_q <= pwdata[3:0];
				REG_X_FACTOR:     cfg_xf_q <= pwdata[4:0];
				REG_Y_FACTOR:     cfg_yf_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_w_q);
			REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_h_q);
			REG_COMPONENTS:   prdata = APB_DW'(cfg_nc_q);
			REG_X_FACTOR:     prdata = APB_DW'(cfg_xf_q);
			REG_Y_FACTOR:     prdata = APB_DW'(cfg_yf_q);
			default:          prdata = '0;
		endcase
	end

	// zero acts as one, anything above the build limit acts as the limit
	always_comb begin
		w_eff  = (cfg_w_q == '0) ? wlim_t'(1) :
		         (32'(cfg_w_q) > MAX_WIDTH) ? wlim_t'(MAX_WIDTH) : wlim_t'(cfg_w_q);
		h_eff  = (cfg_h_q == '0) ? hlim_t'(1) :
		         (32'(cfg_h_q) > MAX_HEIGHT) ? hlim_t'(MAX_HEIGHT) : hlim_t'(cfg_h_q);
		nc_eff = (cfg_nc_q == '0) ? klim_t'(1) :
		         (32'(cfg_nc_q) > MAX_COMPONENTS) ? klim_t'(MAX_COMPONENTS) :
		         klim_t'(cfg_nc_q);
		xf_eff = (cfg_xf_q == '0) ? flim_t'(1) :
		         (32'(cfg_xf_q) > MAX_FACTOR) ? flim_t'(MAX_FACTOR) : flim_t'(cfg_xf_q);
		yf_eff = (cfg_yf_q == '0) ? flim_t'(1) :
		         (32'(cfg_yf_q) > MAX_FACTOR) ? flim_t'(MAX_FACTOR) : flim_t'(cfg_yf_q);
	end

	// ------------------------------------------------------------------
	// Stage 0: positions and run sums
	// ------------------------------------------------------------------
	assign en           = !result_valid_q || result_ready;
	assign sample_ready = en;
	assign acc          = sample_valid && en;

	bfd_seq #(
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.MAX_FACTOR     (MAX_FACTOR)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.din    (sample_data),
		.w_eff  (w_eff),
		.h_eff  (h_eff),
		.nc_eff (nc_eff),
		.xf_eff (xf_eff),
		.yf_eff (yf_eff),
		.rs_new (rs_new),
		.grp    (grp0),
		.rib    (rib0),
		.comp   (comp0),
		.ocol   (ocol0),
		.orow   (orow0),
		.ctl    (ctl0)
	);

	always_comb begin
		tag0.comp = OUT_CMP_W'(comp0);
		tag0.col  = OUT_COL_W'(ocol0);
		tag0.row  = OUT_ROW_W'(orow0);
		tag0.last = ctl0.frame_end;
	end

	// column memory: read at accept, write back from stage 2
	bfd_colmem #(
		.AW (AW)
	) u_colmem (
		.clk       (clk),
		.en        (en),
		.rd_addr   ({ocol0, comp0}),
		.rd_data_q (rd_s1),
		.we        (col_we),
		.wr_addr   (idx_s2),
		.wr_data   (col_new)
	);

	// ------------------------------------------------------------------
	// Stage 1: horizontal divide
	// ------------------------------------------------------------------
	bfd_div #(
		.MAX_FACTOR (MAX_FACTOR)
	) u_div_run (
		.clk      (clk),
		.en       (en),
		.dividend (rs_s1),
		.dsel     (grp_s1),
		.quo      (avg_s2)
	);

	// ------------------------------------------------------------------
	// Stage 2: band accumulate, forwarding from the two writes in flight
	// ------------------------------------------------------------------
	assign wv_s3 = v_s3 && ctl_s3.run_end;
	assign wv_s4 = v_s4 && ctl_s4.run_end;

	always_comb begin
		if (wv_s3 && (idx_s3 == idx_s2)) begin
			col_base = col_s3;
		end else if (wv_s4 && (idx_s4 == idx_s2)) begin
			col_base = col_s4;
		end else begin
			col_base = rd_s2;
		end
		col_new = ctl_s2.row0 ? {{(SUM_W-8){1'b0}}, avg_s2}
		                      : sat_add(col_base, {{(SUM_W-8){1'b0}}, avg_s2});
		col_we  = en && v_s2 && ctl_s2.run_end;
	end

	// ------------------------------------------------------------------
	// Stage 3: vertical divide
	// ------------------------------------------------------------------
	bfd_div #(
		.MAX_FACTOR (MAX_FACTOR)
	) u_div_band (
		.clk      (clk),
		.en       (en),
		.dividend (col_s3),
		.dsel     (rib_s3),
		.quo      (quo_s4)
	);

	assign res_s4 = v_s4 && ctl_s4.run_end && ctl_s4.band_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			v_s4           <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			v_s1           <= acc;
			v_s2           <= v_s1;
			v_s3           <= v_s2;
			v_s4           <= v_s3;
			result_valid_q <= res_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl0;
			tag_s1 <= tag0;
			idx_s1 <= {ocol0, comp0};
			rs_s1  <= rs_new;
			grp_s1 <= grp0;
			rib_s1 <= rib0;

			ctl_s2 <= ctl_s1;
			tag_s2 <= tag_s1;
			idx_s2 <= idx_s1;
			rib_s2 <= rib_s1;
			rd_s2  <= rd_s1;

			ctl_s3 <= ctl_s2;
			tag_s3 <= tag_s2;
			idx_s3 <= idx_s2;
			rib_s3 <= rib_s2;
			col_s3 <= col_new;

			ctl_s4 <= ctl_s3;
			tag_s4 <= tag_s3;
			idx_s4 <= idx_s3;
			col_s4 <= col_s3;

			if (res_s4) begin
				result_q.out_value     <= quo_s4;
				result_q.out_component <= tag_s4.comp;
				result_q.out_col       <= tag_s4.col;
				result_q.out_row       <= tag_s4.row;
				result_q.frame_end     <= tag_s4.last;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bfd_chk.sv -----
// ----------------------------------------------------------------------------
// bfd_chk
// Port-level checks for the box filter downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire bfd_pkg::px_out_t  result_data,
	input wire logic              pready
);
	import bfd_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result payload changed while stalled");

	// input side stalls only behind a held result beat
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("sample stalled with output free");

	// reset has taken hold by the next edge
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |=> !result_valid && sample_ready && pready)
		else $error("outputs active in reset");

	// ready stays known after every accepted beat
	a_sv_known: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !$isunknown(sample_ready))
		else $error("sample_ready unknown after accept");

endmodule

bind box_filter_image_downscale bfd_chk u_bfd_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data),
	.pready       (pready)
);

`default_nettype wire

// ----- tb/bfd_downscale_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfd_downscale_checker
// Watches the sample, result and register ports of the downscaler, keeps its
// own copy of the filter state and compares every result beat in order.
// ----------------------------------------------------------------------------

module bfd_downscale_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_ready,
	input  bfd_pkg::px_in_t               sample_data,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  bfd_pkg::px_out_t              result_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bfd_pkg::APB_AW-1:0]    paddr,
	input  logic [bfd_pkg::APB_DW-1:0]    pwdata,
	input  logic                          pready,
	output int                            fail_count,
	output int                            pending
);
	import bfd_pkg::*;

	localparam int COL_WORDS  = 4096 * 8;
	localparam int REPORT_MAX = 10;

	// raw register contents, limits applied per beat
	logic [12:0] cfg_width, cfg_height;
	logic [3:0]  cfg_comps;
	logic [4:0]  cfg_xf, cfg_yf;

	logic [11:0] run_sum  [0:7];
	logic [11:0] band_sum [0:COL_WORDS-1];
	logic [2:0]  comp_q;
	logic [11:0] pix_col_q, col_q, pix_row_q, row_q;
	logic [4:0]  grp_q, band_row_q;

	px_out_t queued_bytes [$];
	px_out_t want_px;
	int      reports;

	function automatic logic [12:0] limit_reg(input logic [12:0] v, input logic [12:0] hi);
		if (v == 13'd0)
			return 13'd1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic logic [11:0] add_clip(input logic [11:0] a, input logic [11:0] b);
		logic [12:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > 13'd4095) ? 12'hFFF : s[11:0];
	endfunction

	task automatic advance_box_filter(input px_in_t beat);
		logic [12:0] w, h, nc, xf, yf;
		logic        last_comp, row_end, run_end, img_end, band_end;
		logic [11:0] avg, band_avg;
		logic [14:0] slot;
		px_out_t     res;
		w  = limit_reg(cfg_width, 13'd4096);
		h  = limit_reg(cfg_height, 13'd4096);
		nc = limit_reg({9'd0, cfg_comps}, 13'd8);
		xf = limit_reg({8'd0, cfg_xf}, 13'd16);
		yf = limit_reg({8'd0, cfg_yf}, 13'd16);

		if (beat.frame_start) begin
			comp_q     = '0;
			pix_col_q  = '0;
			grp_q      = '0;
			col_q      = '0;
			band_row_q = '0;
			pix_row_q  = '0;
			row_q      = '0;
		end

		// a counter left past a lowered limit counts as at its last position
		last_comp = ({10'd0, comp_q} + 13'd1) >= nc;
		row_end   = ({1'b0, pix_col_q} + 13'd1) >= w;
		run_end   = row_end || (({8'd0, grp_q} + 13'd1) >= xf);
		img_end   = ({1'b0, pix_row_q} + 13'd1) >= h;
		band_end  = img_end || (({8'd0, band_row_q} + 13'd1) >= yf);

		run_sum[comp_q] = (grp_q == 5'd0) ? {4'd0, beat.sample}
			: add_clip(run_sum[comp_q], {4'd0, beat.sample});
		if (run_end) begin
			avg = run_sum[comp_q] / ({7'd0, grp_q} + 12'd1);
			if (avg > 12'd255)
				avg = 12'd255;
			slot = {col_q, comp_q};
			band_sum[slot] = (band_row_q == 5'd0) ? avg : add_clip(band_sum[slot], avg);
			if (band_end) begin
				band_avg = band_sum[slot] / ({7'd0, band_row_q} + 12'd1);
				if (band_avg > 12'd255)
					band_avg = 12'd255;
				res.out_value     = band_avg[7:0];
				res.out_component = comp_q;
				res.out_col       = col_q;
				res.out_row       = row_q;
				res.frame_end     = img_end && row_end && last_comp;
				queued_bytes.push_back(res);
			end
		end

		if (!last_comp) begin
			comp_q = comp_q + 3'd1;
		end else begin
			comp_q = '0;
			if (!run_end) begin
				grp_q     = grp_q + 5'd1;
				pix_col_q = pix_col_q + 12'd1;
			end else begin
				grp_q = '0;
				if (!row_end) begin
					pix_col_q = pix_col_q + 12'd1;
					col_q     = col_q + 12'd1;
				end else begin
					pix_col_q = '0;
					col_q     = '0;
					if (img_end) begin
						pix_row_q  = '0;
						band_row_q = '0;
						row_q      = '0;
					end else begin
						pix_row_q = pix_row_q + 12'd1;
						if (band_end) begin
							band_row_q = '0;
							row_q      = row_q + 12'd1;
						end else begin
							band_row_q = band_row_q + 5'd1;
						end
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width  = 13'd1;
			cfg_height = 13'd1;
			cfg_comps  = 4'd1;
			cfg_xf     = 5'd1;
			cfg_yf     = 5'd1;
			for (int i = 0; i < 8; i++)
				run_sum[i] = '0;
			for (int i = 0; i < COL_WORDS; i++)
				band_sum[i] = '0;
			comp_q     = '0;
			pix_col_q  = '0;
			grp_q      = '0;
			col_q      = '0;
			band_row_q = '0;
			pix_row_q  = '0;
			row_q      = '0;
			queued_bytes.delete();
			fail_count = 0;
			reports    = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (queued_bytes.size() == 0) begin
					fail_count++;
					if (reports < REPORT_MAX)
						$display("unexpected result beat: value %0d comp %0d col %0d row %0d end %0b",
							result_data.out_value, result_data.out_component,
							result_data.out_col, result_data.out_row, result_data.frame_end);
					reports++;
				end else begin
					want_px = queued_bytes.pop_front();
					if (result_data !== want_px) begin
						fail_count++;
						if (reports < REPORT_MAX)
							$display("result mismatch: expected value %0d comp %0d col %0d row %0d end %0b,",
								want_px.out_value, want_px.out_component, want_px.out_col,
								want_px.out_row, want_px.frame_end,
								" got value %0d comp %0d col %0d row %0d end %0b",
								result_data.out_value, result_data.out_component,
								result_data.out_col, result_data.out_row, result_data.frame_end);
						reports++;
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_IMAGE_WIDTH:  cfg_width  = pwdata[12:0];
					REG_IMAGE_HEIGHT: cfg_height = pwdata[12:0];
					REG_COMPONENTS:   cfg_comps  = pwdata[3:0];
					REG_X_FACTOR:     cfg_xf     = pwdata[4:0];
					REG_Y_FACTOR:     cfg_yf     = pwdata[4:0];
					default: ;
				endcase
			end
			if (sample_valid && sample_ready)
				advance_box_filter(sample_data);
		end
		pending = queued_bytes.size();
	end

endmodule

// ----- tb/tb_box_filter_image_downscale.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_filter_image_downscale
// Drives images through the downscaler under changing register settings and
// flow control; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------

module tb_box_filter_image_downscale;
	import bfd_pkg::*;

	localparam int ITEM_TARGET  = 1350;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	px_in_t            sample_data  = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	px_out_t           result_data;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [APB_AW-1:0] paddr        = '0;
	logic [APB_DW-1:0] pwdata       = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int   mismatches;
	int   outstanding;
	int   src_idle_pct   = 0;
	int   sink_stall_pct = 0;
	logic hold_req       = 1'b0;
	logic hold_taken     = 1'b0;
	int   hold_left      = 0;
	int   cycles         = 0;

	// effective register values, used to place frame starts and to pick lowered limits
	int eff_w, eff_h, eff_nc, eff_xf, eff_yf;
	int img_left, items_sent;

	box_filter_image_downscale dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	bfd_downscale_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.fail_count   (mismatches),
		.pending      (outstanding)
	);

	always #2 clk = ~clk;

	// result sink: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			hold_taken   <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("box_filter_image_downscale regression: fail");
		$finish;
	end

	function automatic int eff_of(input int raw, input int hi);
		if (raw == 0)
			return 1;
		return (raw > hi) ? hi : raw;
	endfunction

	function automatic int pick_dim(input int typical_hi);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 0;
		if (r < 10)
			return $urandom_range(8191, 4097);
		if (r < 14)
			return 4096;
		if (r < 20)
			return 1;
		return $urandom_range(typical_hi, 1);
	endfunction

	function automatic int pick_factor();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 0;
		if (r < 12)
			return $urandom_range(31, 17);
		if (r < 22)
			return 16;
		return $urandom_range(8, 1);
	endfunction

	// entered at a falling edge; leaves psel high for a back-to-back write
	task automatic write_reg(input reg_idx_t idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_config(input int w, input int h, input int nc, input int xf, input int yf);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_COMPONENTS, nc);
		write_reg(REG_X_FACTOR, xf);
		write_reg(REG_Y_FACTOR, yf);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		eff_w  = eff_of(w, 4096);
		eff_h  = eff_of(h, 4096);
		eff_nc = eff_of(nc, 8);
		eff_xf = eff_of(xf, 16);
		eff_yf = eff_of(yf, 16);
	endtask

	// entered and left at a falling edge; valid stays up between beats unless an idle gap is drawn
	task automatic offer_sample(input px_in_t beat);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_data  <= beat;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// no beat in flight: every expected result in, plus zero-result beats flushed
	task automatic settle();
		sample_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	initial begin
		px_in_t beat;
		int     phase, budget, mode, comps_raw, r;
		logic   cont, fs;

		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		eff_w  = 1;
		eff_h  = 1;
		eff_nc = 1;
		eff_xf = 1;
		eff_yf = 1;

		// reset values: every beat is a whole output image
		offer_sample('{sample: 8'hFF, frame_start: 1'b1});
		offer_sample('{sample: 8'h00, frame_start: 1'b0});
		settle();

		// zero in every register acts as one
		set_config(0, 0, 0, 0, 0);
		offer_sample('{sample: 8'h80, frame_start: 1'b1});
		offer_sample('{sample: 8'h7F, frame_start: 1'b0});
		settle();

		// short run at the row end, short final band
		set_config(3, 3, 2, 2, 2);
		for (int i = 0; i < 18; i++) begin
			beat.sample      = (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'(i * 29);
			beat.frame_start = (i == 0);
			offer_sample(beat);
		end

		phase      = 0;
		img_left   = 0;
		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			mode = phase % 4;
			settle();
			src_idle_pct    = (mode == 1) ? 84 : (mode == 3) ? 12 : 0;
			sink_stall_pct <= (mode == 2) ? 84 : (mode == 3) ? 12 : 0;
			cont = 1'b0;
			if (phase == 4) begin
				// result every beat, sink held off: the block fills and stalls samples
				set_config(16, 4, 2, 1, 1);
				hold_req <= 1'b1;
				budget = 200;
			end else if (phase > 0 && img_left != 0 && $urandom_range(3) == 0) begin
				// carry on mid-image with limits lowered; run length kept so the
				// column sums of the current band stay valid
				cont = 1'b1;
				set_config($urandom_range(eff_w, 1), $urandom_range(eff_h, 1),
					$urandom_range(eff_nc, 1), eff_xf, $urandom_range(eff_yf, 1));
				img_left = $urandom_range(eff_w * eff_h * eff_nc);
				budget = $urandom_range(160, 40);
			end else begin
				r = $urandom_range(99);
				if (r < 8)
					comps_raw = 0;
				else if (r < 16)
					comps_raw = $urandom_range(15, 9);
				else if (r < 25)
					comps_raw = 8;
				else
					comps_raw = $urandom_range(4, 1);
				set_config(pick_dim(24), pick_dim(8), comps_raw, pick_factor(), pick_factor());
				budget = $urandom_range(160, 40);
			end

			for (int i = 0; i < budget; i++) begin
				r = $urandom_range(9);
				beat.sample = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
				if (i == 0 && !cont)
					fs = 1'b1;
				else if (img_left == 0)
					fs = ($urandom_range(3) != 0);
				else
					fs = ($urandom_range(99) < 2);
				beat.frame_start = fs;
				if (fs || img_left == 0)
					img_left = eff_w * eff_h * eff_nc;
				img_left--;
				offer_sample(beat);
				items_sent++;
			end
			phase++;
		end

		settle();
		if (mismatches == 0)
			$display("box_filter_image_downscale regression: pass");
		else
			$display("box_filter_image_downscale regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_seq.sv
hw/rtl/bfd_div.sv
hw/rtl/bfd_colmem.sv
hw/rtl/box_filter_image_downscale.sv
hw/rtl/bfd_chk.sv
tb/bfd_downscale_checker.sv
tb/tb_box_filter_image_downscale.sv
